@@ src/pfba_pkg.sv @@
// pfba_pkg: shared types and constants for the page frame bitmap allocator.
// Holds the opcode codes, the transaction payload structs and the bitmap command struct.
// No dependencies.
package pfba_pkg;

  // Opcodes of an input transaction
  localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd1;
  localparam logic [2:0] OP_ADD_REF   = 3'd2;
  localparam logic [2:0] OP_GET_REFS  = 3'd3;
  localparam logic [2:0] OP_FREE      = 3'd4;
  localparam logic [2:0] OP_RESERVE   = 3'd5;
  localparam logic [2:0] OP_RELEASE   = 3'd6;
  localparam logic [2:0] OP_ENABLE    = 3'd7;

  localparam int          PAGE_SHIFT = 12;
  localparam logic [11:0] PAGE_MASK  = 12'hFFF;
  localparam logic [12:0] FREE_MAX   = 13'h1FFF;
  localparam logic [15:0] REF_MAX    = 16'hFFFF;

  // What the frame walk does at each frame it visits
  typedef enum logic [2:0] {
    W_SCAN,
    W_CLAIM,
    W_SET,
    W_REL,
    W_SEED
  } walk_mode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [32:0] phys_address;
    logic [32:0] range_end_address;
    logic [12:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] frame_address;
    logic [15:0] ref_count;
    logic [12:0] free_count;
  } out_item_t;

  // Sequencer to bitmap store
  typedef struct packed {
    logic       load;
    logic       grab;
    logic       store;
    logic       set_bit;
    logic       clr_bit;
    logic [4:0] sel;
  } bm_cmd_t;

endpackage

@@ src/page_frame_bitmap_allocator.sv @@
// page_frame_bitmap_allocator: frame allocator top level, sequencer and reference count memory.
// Requests rejected at decode go straight from setup to the result; reference ops read the count, then use it;
// a bitmap walk visits each 32-frame row in turn (load, capture, a step per frame visited, write
// back), and a run search that finds its window walks it again to claim it.
// One transaction at a time: the next is accepted in the cycle after the result register is loaded.
// Reset is synchronous; a clearing pass then fills every bitmap row with ones.
module page_frame_bitmap_allocator #(
  parameter int FRAMES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [12:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfba_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfba_pkg::out_item_t  out_data
);

  localparam int IDX_W  = $clog2(FRAMES);
  localparam int TOT_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = TOT_W > 13 ? TOT_W : 13;
  localparam int ADR_W  = 22;
  localparam int WORDS  = (FRAMES + 31) / 32;
  localparam int WIDX_W = WORDS > 1 ? $clog2(WORDS) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_GRAB  = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_STORE = 9'b000100000,
    S_RREAD = 9'b001000000,
    S_RUSE  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t               state;
  pfba_pkg::walk_mode_t mode;
  pfba_pkg::in_item_t   in_r;
  logic [12:0]          total_cfg;
  logic [TOT_W-1:0]     total;
  logic [12:0]          free_total;
  logic [IDX_W-1:0]     hint;
  logic                 counting_on;
  logic [TOT_W-1:0]     cur, stop, run, nlen, lim, claim_start;
  logic                 hint_set;
  logic                 res_ok;
  logic [31:0]          res_addr;
  logic [15:0]          res_refs;

  // reference counts, undefined until written
  logic [15:0]          ref_mem [FRAMES];
  logic [15:0]          ref_rdata;
  logic                 ref_re, ref_we;
  logic [IDX_W-1:0]     ref_waddr, ref_raddr;
  logic [15:0]          ref_wdata;

  pfba_pkg::bm_cmd_t    bm_cmd;
  logic [WIDX_W-1:0]    bm_row;
  logic                 bm_busy, bm_bit;

  // decoded request
  logic [20:0]          pidx;
  logic                 pidx_ok, aligned;
  logic [ADR_W-1:0]     rng_first, rng_last;
  logic [12:0]          n_sel;
  logic [TOT_W-1:0]     cur_inc, run_inc;
  logic                 step_stop;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !bm_busy;

  assign total = (CMP_W'(total_cfg) < CMP_W'(FRAMES)) ? TOT_W'(total_cfg) : TOT_W'(FRAMES);

  assign pidx    = in_r.phys_address[32:pfba_pkg::PAGE_SHIFT];
  assign pidx_ok = ADR_W'(pidx) < ADR_W'(total);
  assign aligned = in_r.phys_address[11:0] == 12'd0;
  assign n_sel   = (in_r.opcode == pfba_pkg::OP_ALLOC_ONE) ? 13'd1 : in_r.run_length;

  // range bounds: outward alignment for reserve, inward for release
  always_comb begin
    if (in_r.opcode == pfba_pkg::OP_RESERVE) begin
      rng_first = ADR_W'(pidx);
      rng_last  = ADR_W'((34'(in_r.range_end_address) + 34'(pfba_pkg::PAGE_MASK)) >> 12);
    end else begin
      rng_first = ADR_W'((34'(in_r.phys_address) + 34'(pfba_pkg::PAGE_MASK)) >> 12);
      rng_last  = ADR_W'(in_r.range_end_address[32:pfba_pkg::PAGE_SHIFT]);
    end
  end

  assign cur_inc   = cur + TOT_W'(1);
  assign run_inc   = run + TOT_W'(1);
  assign step_stop = (cur_inc == stop) || (cur_inc[4:0] == 5'd0);

  // bitmap commands
  always_comb begin
    bm_cmd         = '0;
    bm_cmd.load    = state == S_LOAD;
    bm_cmd.grab    = state == S_GRAB;
    bm_cmd.store   = state == S_STORE;
    bm_cmd.sel     = cur[4:0];
    bm_cmd.set_bit = (state == S_STEP) &&
                     ((mode == pfba_pkg::W_CLAIM) || ((mode == pfba_pkg::W_SET) && !bm_bit));
    bm_cmd.clr_bit = (state == S_STEP) && (mode == pfba_pkg::W_REL) && bm_bit;
  end

  assign bm_row = WIDX_W'(cur >> 5);

  pfba_bitmap #(
    .FRAMES(FRAMES)
  ) u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .cmd    (bm_cmd),
    .row    (bm_row),
    .busy   (bm_busy),
    .bit_val(bm_bit)
  );

  // reference count port controls
  always_comb begin
    ref_re    = state == S_RREAD;
    ref_raddr = IDX_W'(pidx);
    ref_we    = 1'b0;
    ref_waddr = IDX_W'(pidx);
    ref_wdata = ref_rdata;
    if (state == S_STEP) begin
      ref_waddr = IDX_W'(cur);
      if (mode == pfba_pkg::W_CLAIM) begin
        ref_we    = counting_on;
        ref_wdata = 16'd1;
      end else if (mode == pfba_pkg::W_SEED) begin
        ref_we    = 1'b1;
        ref_wdata = {15'd0, bm_bit};
      end
    end else if (state == S_RUSE) begin
      if (in_r.opcode == pfba_pkg::OP_ADD_REF) begin
        ref_we    = ref_rdata != pfba_pkg::REF_MAX;
        ref_wdata = ref_rdata + 16'd1;
      end else if (in_r.opcode == pfba_pkg::OP_FREE) begin
        ref_we    = ref_rdata != 16'd0;
        ref_wdata = ref_rdata - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (ref_re) begin
      ref_rdata <= ref_mem[ref_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      free_total  <= '0;
      hint        <= '0;
      counting_on <= 1'b0;
      total_cfg   <= '0;
    end else begin
      if (cfg_valid) begin
        total_cfg <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_r  <= in_data;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          res_ok   <= 1'b0;
          res_addr <= '0;
          res_refs <= '0;
          run      <= '0;
          hint_set <= 1'b0;
          state    <= S_DONE;
          case (in_r.opcode)
            pfba_pkg::OP_ALLOC_ONE, pfba_pkg::OP_ALLOC_RUN: begin
              if (n_sel != 13'd0 && CMP_W'(n_sel) <= CMP_W'(total) &&
                  ADR_W'(hint) < ADR_W'(total)) begin
                nlen  <= TOT_W'(n_sel);
                lim   <= total - TOT_W'(n_sel);
                mode  <= pfba_pkg::W_SCAN;
                cur   <= TOT_W'(hint);
                stop  <= total;
                state <= S_LOAD;
              end
            end
            pfba_pkg::OP_ADD_REF, pfba_pkg::OP_GET_REFS: begin
              if (pidx_ok) begin
                state <= S_RREAD;
              end
            end
            pfba_pkg::OP_FREE: begin
              if (aligned && pidx_ok) begin
                if (counting_on) begin
                  state <= S_RREAD;
                end else begin
                  mode  <= pfba_pkg::W_REL;
                  cur   <= TOT_W'(pidx);
                  stop  <= TOT_W'(pidx) + TOT_W'(1);
                  state <= S_LOAD;
                end
              end
            end
            pfba_pkg::OP_RESERVE, pfba_pkg::OP_RELEASE: begin
              if (rng_last > rng_first && rng_first < ADR_W'(total)) begin
                mode  <= (in_r.opcode == pfba_pkg::OP_RESERVE) ? pfba_pkg::W_SET
                                                               : pfba_pkg::W_REL;
                cur   <= TOT_W'(rng_first);
                stop  <= (rng_last > ADR_W'(total)) ? total : TOT_W'(rng_last);
                state <= S_LOAD;
              end
            end
            default: begin
              counting_on <= 1'b1;
              if (total != '0) begin
                mode  <= pfba_pkg::W_SEED;
                cur   <= '0;
                stop  <= total;
                state <= S_LOAD;
              end
            end
          endcase
        end
        S_LOAD: begin
          state <= S_GRAB;
        end
        S_GRAB: begin
          state <= S_STEP;
        end
        S_STEP: begin
          cur   <= cur_inc;
          state <= step_stop ? S_STORE : S_STEP;
          case (mode)
            pfba_pkg::W_SCAN: begin
              if (bm_bit) begin
                run <= '0;
              end else begin
                if (!hint_set && cur <= lim) begin
                  hint     <= IDX_W'(cur);
                  hint_set <= 1'b1;
                end
                run <= run_inc;
                // window complete: go back and claim it
                if (run_inc == nlen) begin
                  claim_start <= cur_inc - nlen;
                  cur         <= cur_inc - nlen;
                  stop        <= cur_inc;
                  mode        <= pfba_pkg::W_CLAIM;
                  state       <= S_STORE;
                end
              end
            end
            pfba_pkg::W_CLAIM: begin
              if (cur_inc == stop) begin
                res_ok     <= 1'b1;
                res_addr   <= 32'({claim_start, 12'd0});
                free_total <= (CMP_W'(free_total) > CMP_W'(nlen))
                              ? free_total - 13'(nlen) : 13'd0;
              end
            end
            pfba_pkg::W_SET: begin
              if (!bm_bit && free_total != 13'd0) begin
                free_total <= free_total - 13'd1;
              end
            end
            pfba_pkg::W_REL: begin
              if (bm_bit) begin
                if (free_total != pfba_pkg::FREE_MAX) begin
                  free_total <= free_total + 13'd1;
                end
                if (cur < TOT_W'(hint)) begin
                  hint <= IDX_W'(cur);
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_STORE: begin
          state <= (cur < stop) ? S_LOAD : S_DONE;
        end
        S_RREAD: begin
          state <= S_RUSE;
        end
        S_RUSE: begin
          state <= S_DONE;
          case (in_r.opcode)
            pfba_pkg::OP_ADD_REF: begin
              res_ok <= ref_rdata != pfba_pkg::REF_MAX;
            end
            pfba_pkg::OP_GET_REFS: begin
              res_refs <= ref_rdata;
            end
            default: begin
              // count drops to zero: release the frame
              if (ref_rdata == 16'd1) begin
                mode  <= pfba_pkg::W_REL;
                cur   <= TOT_W'(pidx);
                stop  <= TOT_W'(pidx) + TOT_W'(1);
                state <= S_LOAD;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.ok            <= res_ok;
            out_data.frame_address <= res_addr;
            out_data.ref_count     <= res_refs;
            out_data.free_count    <= free_total;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_SETUP)
    else $error("accepted transaction did not start setup");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    bm_busy |-> state == S_IDLE)
    else $error("sequencer active during bitmap clearing pass");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> cur < stop)
    else $error("frame walk stepped past its end");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP && mode == pfba_pkg::W_CLAIM |-> !bm_bit)
    else $error("claiming a frame that is already used");

endmodule

@@ src/pfba_bitmap.sv @@
// pfba_bitmap: used/free bitmap memory, one 32-bit row per 32 frames, with a working row
// register that the sequencer loads, edits bit by bit and writes back. Fills all ones after reset.
// Depends on pfba_pkg.
module pfba_bitmap #(
  parameter int FRAMES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  pfba_pkg::bm_cmd_t cmd,
  input  logic [((FRAMES + 31) / 32 > 1 ? $clog2((FRAMES + 31) / 32) : 1) - 1:0] row,
  output logic             busy,
  output logic             bit_val
);

  localparam int WORDS  = (FRAMES + 31) / 32;
  localparam int WIDX_W = WORDS > 1 ? $clog2(WORDS) : 1;

  logic [31:0]       mem [WORDS];
  logic [31:0]       rdata;
  logic [31:0]       word;
  logic [WIDX_W-1:0] row_q;
  logic [WIDX_W-1:0] clr_row;

  // clearing pass: every frame starts out used
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + WIDX_W'(1);
      if (clr_row == WIDX_W'(WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '1;
    end else if (cmd.store) begin
      mem[row_q] <= word;
    end
    if (cmd.load) begin
      rdata <= mem[row];
      row_q <= row;
    end
  end

  // working row
  always_ff @(posedge clk) begin
    if (cmd.grab) begin
      word <= rdata;
    end else if (cmd.set_bit) begin
      word[cmd.sel] <= 1'b1;
    end else if (cmd.clr_bit) begin
      word[cmd.sel] <= 1'b0;
    end
  end

  assign bit_val = word[cmd.sel];

endmodule
